### rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared constants, codes and word types of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int BATCH_SAMPLES = 64;
  localparam int MAX_STEPS     = 50;

  localparam int BATCH_SHIFT = $clog2(BATCH_SAMPLES);
  localparam int DW          = 24;
  localparam int SUM_W       = DW + BATCH_SHIFT;
  localparam int CNT_W       = $clog2(BATCH_SAMPLES + 1);
  localparam int STEP_W      = $clog2(MAX_STEPS + 1);
  localparam int LIM_W       = 52;
  localparam int SQ_W        = 2 * DW + 2;
  localparam int LEN_W       = 2 * DW;

  localparam logic [LIM_W-1:0] MOTION_LIMIT_RST   = LIM_W'(171798692);
  localparam logic [LIM_W-1:0] CONVERGE_LIMIT_RST = LIM_W'(13083);

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PH_COLLECT = 2'd0,
    PH_CALIB   = 2'd1,
    PH_FAILED  = 2'd2,
    PH_SUCCESS = 2'd3
  } phase_e;

  typedef enum logic {
    CFG_MOTION_LIMIT   = 1'b0,
    CFG_CONVERGE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef logic signed [DW-1:0] q_t;

  typedef struct packed {
    logic cmd;
    q_t   gyro_x;
    q_t   gyro_y;
    q_t   gyro_z;
    q_t   accel_x;
    q_t   accel_y;
    q_t   accel_z;
  } sample_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       finished;
    logic       converged_flag;
    q_t         offset_x;
    q_t         offset_y;
    q_t         offset_z;
  } result_t;

  typedef struct packed {
    logic [0:0]       index;
    logic [LIM_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [LIM_W-1:0] motion;
    logic [LIM_W-1:0] converge;
  } limits_t;

  typedef struct packed {
    phase_e                  phase;
    logic [CNT_W-1:0]        sample_cnt;
    logic [STEP_W-1:0]       step_cnt;
    logic [2:0][SUM_W-1:0]   sums;
    logic [2:0][DW-1:0]      accel_start;
    logic [2:0][DW-1:0]      last_avg;
    logic [2:0][DW-1:0]      best_avg;
    logic [2:0][DW-1:0]      new_off;
    logic [LEN_W-1:0]        new_off_len;
    logic [LIM_W-1:0]        best_diff;
    logic                    converged;
  } state_t;

endpackage

### rtl/gbc_sample_if.sv
// ----------------------------------------------------------------------------
// gbc_sample_if
// Sample channel: command and raw gyro and accelerometer vectors.
// ----------------------------------------------------------------------------
interface gbc_sample_if import gbc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gbc_result_if.sv
// ----------------------------------------------------------------------------
// gbc_result_if
// Result channel: phase, completion, convergence and bias offsets.
// ----------------------------------------------------------------------------
interface gbc_result_if import gbc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gbc_cfg_if.sv
// ----------------------------------------------------------------------------
// gbc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gbc_cfg_if import gbc_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gyro_bias_calibrator_core.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_core
// Gyro bias estimation by batch averaging with convergence tracking.
//
// sample_i carries one word per IMU sample: a start command, or a sample
// update with gyro and accelerometer vectors in Q8.16. Every sample word
// gives exactly one result word on result_o: phase, finished flag,
// converged flag and the current bias offsets.
// cfg_i writes the squared motion limit and the squared convergence limit
// (Q32); it is always ready and should only be used while the block is idle.
// Throughput is one word per cycle while result_o is not stalled. A word
// accepted sits in the input register, is processed in a single pass into
// the result register, and can be taken from there. The single pass is set
// by the squared-length datapath of the evaluation. When result_o stalls,
// one more word is held in the input register, then sample_i ready drops
// until the result is taken.
// Reset clears all calibration state to zero, puts the block in the
// collecting phase and loads the default limits.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_core import gbc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gbc_sample_if.sink    sample_i,
  gbc_cfg_if.sink       cfg_i,
  gbc_result_if.source  result_o
);

  logic    item_valid;
  sample_t item;
  logic    adv;
  state_t  state_q, state_d;
  limits_t lim_q;
  result_t res_q, res_d;
  logic    res_valid_q;

  assign adv = item_valid && (!res_valid_q || result_o.ready);

  gbc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (sample_i),
    .adv_i   (adv),
    .valid_o (item_valid),
    .data_o  (item)
  );

  gbc_step u_step (
    .item_i (item),
    .st_i   (state_q),
    .lim_i  (lim_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  // limit registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.motion   <= MOTION_LIMIT_RST;
      lim_q.converge <= CONVERGE_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        CFG_MOTION_LIMIT:   lim_q.motion   <= cfg_i.data.value;
        CFG_CONVERGE_LIMIT: lim_q.converge <= cfg_i.data.value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  a_finish_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.finished |->
      (result_o.data.phase == PH_FAILED || result_o.data.phase == PH_SUCCESS))
    else $error("finished word without a final phase");

  a_success_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_SUCCESS |-> state_q.converged)
    else $error("success phase without convergence");

  a_calib_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_CALIB |-> state_q.sample_cnt == CNT_W'(BATCH_SAMPLES))
    else $error("calibrating with an incomplete batch");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item.cmd == CMD_SAMPLE && state_q.phase == PH_COLLECT |=>
      state_q.step_cnt == $past(state_q.step_cnt))
    else $error("step count moved while collecting");

endmodule

### rtl/gbc_in_reg.sv
// ----------------------------------------------------------------------------
// gbc_in_reg
// Input register stage holding one sample word ahead of the update logic.
// ----------------------------------------------------------------------------
module gbc_in_reg import gbc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gbc_sample_if.sink    smp_i,
  input  logic          adv_i,
  output logic          valid_o,
  output sample_t       data_o
);

  logic    valid_q, valid_d;
  sample_t data_q;
  logic    take;

  assign smp_i.ready = !valid_q || adv_i;
  assign take        = smp_i.valid && smp_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= smp_i.data;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/gbc_step.sv
// ----------------------------------------------------------------------------
// gbc_step
// Next-state and result logic for one sample word: batch accumulation,
// motion check, averaging, convergence and best-result tracking.
// ----------------------------------------------------------------------------
module gbc_step import gbc_pkg::*; (
  input  sample_t item_i,
  input  state_t  st_i,
  input  limits_t lim_i,
  output state_t  st_o,
  output result_t res_o
);

  function automatic logic [SQ_W-1:0] sq(input logic signed [DW:0] v);
    logic signed [SQ_W-1:0] p;
    p = (SQ_W)'(v) * (SQ_W)'(v);
    return p;
  endfunction

  logic signed [DW-1:0] gyro [3];
  logic signed [DW-1:0] accel [3];
  logic signed [DW:0]   acc_d [3];
  logic signed [DW:0]   diff [3];
  logic signed [DW:0]   mean_sum [3];
  logic signed [DW-1:0] avg [3];
  logic signed [DW-1:0] mean [3];
  logic [SQ_W-1:0]      acc_sq, diff_sq, mean_sq;
  logic [LEN_W-1:0]     mean_len;
  logic                 moved, first, hit, take, better, end_cal, finished;

  assign gyro[0]  = item_i.gyro_x;
  assign gyro[1]  = item_i.gyro_y;
  assign gyro[2]  = item_i.gyro_z;
  assign accel[0] = item_i.accel_x;
  assign accel[1] = item_i.accel_y;
  assign accel[2] = item_i.accel_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i]    = (DW+1)'(accel[i]) - (DW+1)'($signed(st_i.accel_start[i]));
      avg[i]      = DW'($signed(st_i.sums[i]) >>> BATCH_SHIFT);
      diff[i]     = (DW+1)'($signed(st_i.last_avg[i])) - (DW+1)'(avg[i]);
      mean_sum[i] = (DW+1)'(avg[i]) + (DW+1)'($signed(st_i.last_avg[i]));
      mean[i]     = DW'(mean_sum[i] >>> 1);
    end
    acc_sq   = sq(acc_d[0]) + sq(acc_d[1]) + sq(acc_d[2]);
    diff_sq  = sq(diff[0]) + sq(diff[1]) + sq(diff[2]);
    mean_sq  = sq((DW+1)'(mean[0])) + sq((DW+1)'(mean[1])) + sq((DW+1)'(mean[2]));
    mean_len = mean_sq[LEN_W-1:0];
  end

  assign moved   = LIM_W'(acc_sq) > lim_i.motion;
  assign first   = st_i.step_cnt == '0;
  assign hit     = LIM_W'(diff_sq) < lim_i.converge;
  assign take    = !st_i.converged || (mean_len < st_i.new_off_len);
  assign better  = LIM_W'(diff_sq) < st_i.best_diff;
  assign end_cal = (st_i.step_cnt >= STEP_W'(MAX_STEPS)) || st_i.converged;

  always_comb begin
    st_o     = st_i;
    finished = 1'b0;
    if (item_i.cmd == CMD_START) begin
      st_o.new_off     = '0;
      st_o.new_off_len = '0;
      st_o.last_avg    = '0;
      st_o.best_diff   = '0;
      st_o.converged   = 1'b0;
      st_o.step_cnt    = '0;
      st_o.sample_cnt  = '0;
      st_o.phase       = PH_COLLECT;
    end else begin
      case (st_i.phase)
        PH_CALIB: begin
          if (end_cal) begin
            st_o.phase = st_i.converged ? PH_SUCCESS : PH_FAILED;
            finished   = 1'b1;
          end else begin
            st_o.phase      = PH_COLLECT;
            st_o.sample_cnt = '0;
            if (!moved) begin
              if (first) begin
                st_o.best_diff = LIM_W'(diff_sq);
                for (int i = 0; i < 3; i++) begin
                  st_o.best_avg[i] = avg[i];
                end
              end else if (hit) begin
                if (take) begin
                  st_o.new_off_len = mean_len;
                  for (int i = 0; i < 3; i++) begin
                    st_o.new_off[i] = mean[i];
                  end
                end
                st_o.converged = 1'b1;
              end else if (better) begin
                st_o.best_diff = LIM_W'(diff_sq);
                for (int i = 0; i < 3; i++) begin
                  st_o.best_avg[i] = mean[i];
                end
              end
              for (int i = 0; i < 3; i++) begin
                st_o.last_avg[i] = avg[i];
              end
              st_o.step_cnt = STEP_W'(st_i.step_cnt + 1'b1);
            end
          end
        end
        PH_COLLECT: begin
          for (int i = 0; i < 3; i++) begin
            if (st_i.sample_cnt == '0) begin
              st_o.sums[i]        = SUM_W'(gyro[i]);
              st_o.accel_start[i] = accel[i];
            end else begin
              st_o.sums[i] = st_i.sums[i] + SUM_W'(gyro[i]);
            end
          end
          st_o.sample_cnt = CNT_W'(st_i.sample_cnt + 1'b1);
          if (st_o.sample_cnt == CNT_W'(BATCH_SAMPLES)) begin
            st_o.phase = PH_CALIB;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.phase          = st_o.phase;
    res_o.finished       = finished;
    res_o.converged_flag = st_o.converged;
    res_o.offset_x       = st_o.converged ? st_o.new_off[0] : st_o.best_avg[0];
    res_o.offset_y       = st_o.converged ? st_o.new_off[1] : st_o.best_avg[1];
    res_o.offset_z       = st_o.converged ? st_o.new_off[2] : st_o.best_avg[2];
  end

endmodule
